@@ rtl/core/nns_pkg.sv @@
// ----------------------------------------------------------------------------
// nns_pkg
// shared types and constants of the nearest neighbor scaler
// ----------------------------------------------------------------------------
package nns_pkg;

  // widths fixed by the register map and the transaction fields
  localparam int unsigned IW_W   = 13;  // input_width register
  localparam int unsigned OW_W   = 16;  // output_width register
  localparam int unsigned OH_W   = 16;  // output_height register
  localparam int unsigned INV_W  = 24;  // inverse_step register, q8.16
  localparam int unsigned FRAC_W = 16;  // fraction bits of inverse_step
  localparam int unsigned PROD_W = OW_W + INV_W;  // index times inverse_step
  localparam int unsigned WW     = 17;  // effective width, 1 to MAX_WIDTH
  localparam int unsigned ROWS_W = 17;  // rows loaded counter
  localparam int unsigned PIX_W  = 24;  // packed rgb pixel

  // needed source row saturates here so rows loaded stays in 17 bits
  localparam logic [ROWS_W-1:0] ROW_SAT = 17'h1FFFE;

  typedef enum logic [1:0] {
    CFG_INPUT_WIDTH   = 2'd0,
    CFG_OUTPUT_WIDTH  = 2'd1,
    CFG_OUTPUT_HEIGHT = 2'd2,
    CFG_INVERSE_STEP  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_PULL = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
    logic       image_end;
  } out_item_t;

  // control that travels alongside the line store read
  typedef struct packed {
    logic accepted;
    logic pixel;      // produced pull, pixel comes from the store
    logic row_end;
    logic image_end;
  } s1_ctrl_t;

endpackage

@@ rtl/core/nearest_neighbor_scaler_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler_unit
// nearest neighbor image scaler built around a single line store ram
// ----------------------------------------------------------------------------
// Each input transaction is either a push (store one source pixel into the
// line store) or a pull (emit the next output pixel), and each one yields
// exactly one result transaction; a refused push or pull comes back with
// accepted low and all pixel fields zero. A push is taken while the rows
// loaded have not passed the source row the current output row needs; a pull
// is served once that row is loaded, reading column floor(x*inverse_step)
// clamped to the last input column. Throughput is one transaction per clock
// while the output does not stall; a bubble follows the last pixel of every
// output row and every write of inverse_step, while the registered row
// multiplier re-derives the needed source row (and the column accumulator is
// reloaded). The stage one register captures the synchronous line store read
// and the stage control at the accepting edge; the output register loads from
// it while the output does not stall. The line store needs no clearing pass
// after reset. The user must write configuration only while the block is
// idle; the block does not enforce this, and cfg_ready is held high. After
// the last pixel of the image every transaction is refused until reset.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_unit
  import nns_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // result transaction channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [IW_W-1:0]  in_width_r;
  logic [OW_W-1:0]  out_width_r;
  logic [OH_W-1:0]  out_height_r;
  logic [INV_W-1:0] inv_step_r;

  // scan state
  logic [AW-1:0]     wcol_r, wcol_nxt;
  logic [ROWS_W-1:0] rows_r, rows_nxt;
  logic [OW_W-1:0]   ocol_r, ocol_nxt;
  logic [OH_W-1:0]   orow_r, orow_nxt;
  logic              finished_r, finished_nxt;
  logic [PROD_W-1:0] col_acc_r, col_acc_nxt;   // ocol_r * inv_step_r
  logic [ROWS_W-1:0] need_r;                   // source row for orow_r
  logic              need_ok_r, need_ok_nxt;   // need_r and col_acc_r current

  // pipeline
  logic      s1_valid_r, s1_valid_nxt;
  s1_ctrl_t  s1_ctrl_r, s1_ctrl_nxt;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      s1_adv;

  // datapath
  logic [WW-1:0]     w_eff, w_m1;
  logic [OW_W-1:0]   ow_m1;
  logic [OH_W-1:0]   oh_m1;
  logic [PROD_W-1:0] row_prod, col_prod;
  logic [INV_W-1:0]  row_idx;
  logic [INV_W-1:0]  col_raw, col_clamp;
  logic              in_acc, push_ok, pull_ok, row_last, img_last;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= IW_W'(1);
      out_width_r  <= OW_W'(1);
      out_height_r <= OH_W'(1);
      inv_step_r   <= INV_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_WIDTH:   in_width_r   <= cfg_data[IW_W-1:0];
        CFG_OUTPUT_WIDTH:  out_width_r  <= cfg_data[OW_W-1:0];
        CFG_OUTPUT_HEIGHT: out_height_r <= cfg_data[OH_W-1:0];
        CFG_INVERSE_STEP:  inv_step_r   <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: input width clamped to 1..MAX_WIDTH, zero sizes act as one
  always_comb begin
    w_eff = WW'(in_width_r);
    if (w_eff == '0) begin
      w_eff = WW'(1);
    end else if (w_eff > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    w_m1  = w_eff - WW'(1);
    ow_m1 = (out_width_r == '0) ? '0 : out_width_r - OW_W'(1);
    oh_m1 = (out_height_r == '0) ? '0 : out_height_r - OH_W'(1);
  end

  // ---------------------------------------------------------------------------
  // needed source row: registered multiply, with a bubble after orow or step moves
  // ---------------------------------------------------------------------------
  assign row_prod = PROD_W'(orow_r) * PROD_W'(inv_step_r);
  assign row_idx  = row_prod[PROD_W-1:FRAC_W];
  assign col_prod = PROD_W'(ocol_r) * PROD_W'(inv_step_r);

  always_ff @(posedge clk) begin
    need_r <= (row_idx > INV_W'(ROW_SAT)) ? ROW_SAT : row_idx[ROWS_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // accept decision and state update
  // ---------------------------------------------------------------------------
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = !need_ok_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  assign push_ok  = !finished_r && (rows_r <= need_r);
  assign pull_ok  = !finished_r && (rows_r > need_r);
  assign row_last = ocol_r >= ow_m1;
  assign img_last = orow_r >= oh_m1;

  // source column, clamped to the last input column
  assign col_raw   = col_acc_r[PROD_W-1:FRAC_W];
  assign col_clamp = (col_raw > INV_W'(w_m1)) ? INV_W'(w_m1) : col_raw;
  assign ram_raddr = col_clamp[AW-1:0];

  assign ram_we = in_acc && (in_item.mode == MODE_PUSH) && push_ok;
  assign ram_re = in_acc && (in_item.mode == MODE_PULL) && pull_ok;

  always_comb begin
    wcol_nxt     = wcol_r;
    rows_nxt     = rows_r;
    ocol_nxt     = ocol_r;
    orow_nxt     = orow_r;
    finished_nxt = finished_r;
    col_acc_nxt  = col_acc_r;
    need_ok_nxt  = 1'b1;
    s1_ctrl_nxt  = s1_ctrl_r;
    s1_valid_nxt = s1_valid_r;

    if (!need_ok_r) begin
      // resync cycle: reload the column accumulator from the multiplier
      col_acc_nxt = col_prod;
    end

    if (cfg_we && (cfg_index == CFG_INVERSE_STEP)) begin
      need_ok_nxt = 1'b0;
    end

    if (ram_we) begin
      if (WW'(wcol_r) >= w_m1) begin
        wcol_nxt = '0;
        rows_nxt = rows_r + ROWS_W'(1);
      end else begin
        wcol_nxt = wcol_r + AW'(1);
      end
    end

    if (ram_re) begin
      if (row_last) begin
        ocol_nxt    = '0;
        col_acc_nxt = '0;
        if (img_last) begin
          finished_nxt = 1'b1;
        end else begin
          orow_nxt    = orow_r + OH_W'(1);
          need_ok_nxt = 1'b0;
        end
      end else begin
        ocol_nxt    = ocol_r + OW_W'(1);
        col_acc_nxt = col_acc_r + PROD_W'(inv_step_r);
      end
    end

    if (in_acc) begin
      s1_valid_nxt          = 1'b1;
      s1_ctrl_nxt.accepted  = ram_we || ram_re;
      s1_ctrl_nxt.pixel     = ram_re;
      s1_ctrl_nxt.row_end   = ram_re && row_last;
      s1_ctrl_nxt.image_end = ram_re && row_last && img_last;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r     <= '0;
      rows_r     <= '0;
      ocol_r     <= '0;
      orow_r     <= '0;
      finished_r <= 1'b0;
      col_acc_r  <= '0;
      need_ok_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      wcol_r     <= wcol_nxt;
      rows_r     <= rows_nxt;
      ocol_r     <= ocol_nxt;
      orow_r     <= orow_nxt;
      finished_r <= finished_nxt;
      col_acc_r  <= col_acc_nxt;
      need_ok_r  <= need_ok_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctrl_r <= s1_ctrl_nxt;
  end

  // ---------------------------------------------------------------------------
  // line store: a pull never reads in the cycle of a push, so a read right
  // after a write of the same column already sees the new pixel
  // ---------------------------------------------------------------------------
  nns_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wcol_r),
    .wdata ({in_item.in_red, in_item.in_green, in_item.in_blue}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r.accepted  <= s1_ctrl_r.accepted;
      out_item_r.out_red   <= s1_ctrl_r.pixel ? ram_rdata[23:16] : 8'd0;
      out_item_r.out_green <= s1_ctrl_r.pixel ? ram_rdata[15:8]  : 8'd0;
      out_item_r.out_blue  <= s1_ctrl_r.pixel ? ram_rdata[7:0]   : 8'd0;
      out_item_r.row_end   <= s1_ctrl_r.row_end;
      out_item_r.image_end <= s1_ctrl_r.image_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // nothing is stored once the image is complete
  a_no_push_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !ram_we)
    else $error("line store written after image end");

  // a pull only reads a fully loaded source row
  a_pull_row_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (rows_r > need_r) && need_ok_r)
    else $error("pull served before its row was loaded");

  // a held stage one entry keeps its control while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(s1_ctrl_r))
    else $error("stage one transaction lost under stall");

  // the image only ends on a produced pull
  a_end_from_pull: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(finished_r) |-> $past(ram_re && row_last && img_last))
    else $error("image end without a final pull");

endmodule

@@ rtl/core/nns_ram.sv @@
// ----------------------------------------------------------------------------
// nns_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module nns_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ tb/sv/nearest_neighbor_scaler_unit_tb.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler_unit_tb
// self-checking bench for the nearest neighbor scaler
// ----------------------------------------------------------------------------
// A short directed table walks the reset state, refused pushes and pulls, the
// width and step extremes and the column clamp. It is followed by randomized
// configuration phases of mostly well-formed push and pull traffic, with some
// noise mixed in. The image runs on through every phase and is finished at
// the very end. Each transaction gets its expected result from a local
// scaler model. Results are checked in order, with random gaps on both
// channels, one long output hold and one drain of the sender midway.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nns_pkg::*;

  localparam int unsigned MAX_COLS    = 4096;
  localparam int unsigned PHASES      = 16;
  localparam int unsigned PHASE_ITEMS = 46;   // accepted transactions per phase
  localparam int unsigned HOLD_PHASE  = 3;    // output held off for a long time
  localparam int unsigned PAUSE_PHASE = 7;    // sender drains the block midway
  localparam int unsigned HOLD_CYCLES = 300;

  // kinds of rows in the directed table
  typedef enum logic [1:0] {
    ROW_CFG,        // register write, value is the data
    ROW_PREDICTED,  // transaction checked against the scaler model
    ROW_REFUSED,    // transaction that must come back all zero
    ROW_STORED      // push that must come back accepted with zero pixel
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    logic [23:0] value;     // register data, or rgb of the transaction
    mode_t       mode;
  } dir_row_t;

  // directed stimulus, the state is noted after each transaction
  localparam dir_row_t DIR_ROWS [0:29] = '{
    // reset registers: one pixel wide, one by one output
    '{ROW_REFUSED,   CFG_INPUT_WIDTH,   24'hFFFFFF, MODE_PULL},  // nothing loaded yet
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'h123456, MODE_PUSH},  // row 0 loaded
    '{ROW_REFUSED,   CFG_INPUT_WIDTH,   24'hFFFFFF, MODE_PUSH},  // row already there
    '{ROW_CFG,       CFG_OUTPUT_WIDTH,  24'd2,      MODE_PUSH},
    '{ROW_CFG,       CFG_OUTPUT_HEIGHT, 24'd65535,  MODE_PUSH},
    '{ROW_PREDICTED, CFG_INPUT_WIDTH,   24'h000000, MODE_PULL},
    '{ROW_PREDICTED, CFG_INPUT_WIDTH,   24'h000000, MODE_PULL},  // column clamped, row end
    // oversize width acts as the store depth
    '{ROW_CFG,       CFG_INPUT_WIDTH,   24'd8191,   MODE_PUSH},
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'hFFFFFF, MODE_PUSH},
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'h000000, MODE_PUSH},
    '{ROW_REFUSED,   CFG_INPUT_WIDTH,   24'h5A5A5A, MODE_PULL},  // row 1 only partly in
    '{ROW_CFG,       CFG_INPUT_WIDTH,   24'd4096,   MODE_PUSH},
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'h8001FE, MODE_PUSH},
    // zero width acts as one, so this push closes the row
    '{ROW_CFG,       CFG_INPUT_WIDTH,   24'd0,      MODE_PUSH},
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'h7FFE01, MODE_PUSH},
    '{ROW_CFG,       CFG_INPUT_WIDTH,   24'd4,      MODE_PUSH},
    '{ROW_CFG,       CFG_INVERSE_STEP,  24'd131072, MODE_PUSH},  // shrink by two
    '{ROW_REFUSED,   CFG_INPUT_WIDTH,   24'h000000, MODE_PULL},  // source row 2 needed
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'h010203, MODE_PUSH},
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'hAA55AA, MODE_PUSH},
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'h55AA55, MODE_PUSH},
    '{ROW_STORED,    CFG_INPUT_WIDTH,   24'hFEDCBA, MODE_PUSH},
    '{ROW_PREDICTED, CFG_INPUT_WIDTH,   24'h000000, MODE_PULL},
    '{ROW_PREDICTED, CFG_INPUT_WIDTH,   24'hFFFFFF, MODE_PULL},  // column 2, row end
    // smallest step, zero output width acts as one
    '{ROW_CFG,       CFG_INVERSE_STEP,  24'd655,    MODE_PUSH},
    '{ROW_CFG,       CFG_OUTPUT_WIDTH,  24'd0,      MODE_PUSH},
    '{ROW_REFUSED,   CFG_INPUT_WIDTH,   24'hC3C3C3, MODE_PUSH},
    '{ROW_PREDICTED, CFG_INPUT_WIDTH,   24'h000000, MODE_PULL},
    // largest step pushes the needed row far ahead
    '{ROW_CFG,       CFG_INVERSE_STEP,  24'hFFFFFF, MODE_PUSH},
    '{ROW_REFUSED,   CFG_INPUT_WIDTH,   24'hFFFFFF, MODE_PULL}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [23:0] cfg_data;

  // scaler model: registers
  logic [12:0] reg_in_w;
  logic [15:0] reg_out_w;
  logic [15:0] reg_out_h;
  logic [23:0] reg_step;

  // scaler model: line store and counters
  logic [23:0] line_mem [MAX_COLS];
  bit          line_written [MAX_COLS];
  logic [11:0] wr_col;
  logic [16:0] rows_loaded;
  logic [15:0] out_x;
  logic [15:0] out_y;
  bit          image_done;

  // results still owed by the block, oldest first
  out_item_t   px_expected [$];

  // channel behavior, set per phase
  bit          in_gaps;
  bit          out_gaps;
  int unsigned hold_asked;
  int unsigned holds_done;

  int unsigned n_errors;
  int unsigned n_txn;
  int unsigned n_stored;
  int unsigned n_pixels;
  int unsigned n_refused;
  int unsigned n_row_end;
  int unsigned n_image_end;
  int unsigned n_phases;

  nearest_neighbor_scaler_unit #(
    .MAX_WIDTH (MAX_COLS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ----------------------------------------------------------------------
  // scaler model
  // ----------------------------------------------------------------------

  // input width as the block uses it
  function automatic int unsigned clamp_in_width(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_COLS) return MAX_COLS;
    return v;
  endfunction

  // source row the current output row reads, saturated to fit the counter
  function automatic logic [16:0] needed_src_row();
    longint unsigned r;
    r = (64'(out_y) * 64'(reg_step)) >> FRAC_W;
    if (r > 64'(ROW_SAT)) r = 64'(ROW_SAT);
    return r[16:0];
  endfunction

  // store column the next pull reads, clamped to the last input column
  function automatic int unsigned src_column();
    longint unsigned c;
    int unsigned     w;
    w = clamp_in_width(32'(reg_in_w));
    c = (64'(out_x) * 64'(reg_step)) >> FRAC_W;
    if (c > 64'(w - 1)) c = 64'(w - 1);
    return 32'(c);
  endfunction

  // advance the model by one transaction and return its result
  function automatic out_item_t scale_step(in_item_t it);
    out_item_t   r;
    logic [16:0] need;
    logic [23:0] px;
    int unsigned w;
    int unsigned ow;
    int unsigned oh;
    r = '0;
    if (image_done) return r;
    need = needed_src_row();
    w    = clamp_in_width(32'(reg_in_w));
    if (it.mode == MODE_PUSH) begin
      if (rows_loaded > need) return r;
      line_mem[wr_col]     = {it.in_red, it.in_green, it.in_blue};
      line_written[wr_col] = 1'b1;
      if (32'(wr_col) + 1 >= w) begin
        wr_col = '0;
        rows_loaded++;
      end else begin
        wr_col++;
      end
      r.accepted = 1'b1;
      return r;
    end
    if (rows_loaded <= need) return r;
    ow = (reg_out_w == 0) ? 1 : 32'(reg_out_w);
    oh = (reg_out_h == 0) ? 1 : 32'(reg_out_h);
    px = line_mem[src_column()];
    r.accepted  = 1'b1;
    r.out_red   = px[23:16];
    r.out_green = px[15:8];
    r.out_blue  = px[7:0];
    if (32'(out_x) + 1 >= ow) begin
      r.row_end = 1'b1;
      out_x     = '0;
      if (32'(out_y) + 1 >= oh) begin
        r.image_end = 1'b1;
        image_done  = 1'b1;
      end else begin
        out_y++;
      end
    end else begin
      out_x++;
    end
    return r;
  endfunction

  // ----------------------------------------------------------------------
  // stimulus helpers
  // ----------------------------------------------------------------------

  // mostly the transaction that moves the image on, sometimes a random one
  function automatic in_item_t next_item(bit useful);
    in_item_t it;
    it = '0;
    {it.in_red, it.in_green, it.in_blue} = 24'($urandom);
    if (useful)
      it.mode = (image_done || rows_loaded <= needed_src_row()) ? MODE_PUSH : MODE_PULL;
    else
      it.mode = ($urandom_range(0, 1) != 0) ? MODE_PULL : MODE_PUSH;
    // never let a pull read a store entry that was never written
    if (it.mode == MODE_PULL && !image_done && rows_loaded > needed_src_row() &&
        !line_written[src_column()])
      it.mode = MODE_PUSH;
    return it;
  endfunction

  // offer one transaction and hold it until the block takes it
  task automatic send_txn(in_item_t it, out_item_t want);
    int unsigned gap;
    gap = in_gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    px_expected.push_back(want);
    n_txn++;
    if (!want.accepted) n_refused++;
    else if (it.mode == MODE_PUSH) n_stored++;
    else n_pixels++;
    if (want.row_end) n_row_end++;
    if (want.image_end) n_image_end++;
  endtask

  // stop offering and wait until every owed result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (px_expected.size() != 0);
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_INPUT_WIDTH:   reg_in_w  = val[12:0];
      CFG_OUTPUT_WIDTH:  reg_out_w = val[15:0];
      CFG_OUTPUT_HEIGHT: reg_out_h = val[15:0];
      CFG_INVERSE_STEP:  reg_step  = val;
      default: ;
    endcase
  endtask

  // drain, then rewrite all four registers for a new phase
  task automatic configure_phase(bit last);
    logic [23:0] step;
    int unsigned iw;
    int unsigned ow;
    int unsigned oh;
    int unsigned lim;
    settle();
    case ($urandom_range(0, 9))
      0:       step = 24'd655;
      1:       step = 24'hFFFFFF;
      2:       step = 24'd65536;
      3:       step = 24'd131072;
      4, 5, 6: step = 24'($urandom_range(20000, 65536));
      default: step = 24'($urandom_range(65536, 200000));
    endcase
    // closing phase: smallest step keeps the needed source row near the top
    if (last) step = 24'd655;
    write_reg(CFG_INVERSE_STEP, step);

    // with the current row still in use the width may not reach unwritten columns
    lim = MAX_COLS;
    if (rows_loaded > needed_src_row()) begin
      lim = 0;
      while (lim < MAX_COLS && line_written[lim]) lim++;
    end
    case ($urandom_range(0, 9))
      0:       iw = 0;
      1:       iw = 8191;
      2:       iw = MAX_COLS;
      3:       iw = 1;
      default: iw = $urandom_range(2, 24);
    endcase
    if (step == 24'hFFFFFF) iw = $urandom_range(0, 2);  // keep far-row phases short
    if (last) iw = 1;  // one push loads a whole row
    if (clamp_in_width(iw) > lim) iw = lim;
    write_reg(CFG_INPUT_WIDTH, 24'(iw));

    case ($urandom_range(0, 7))
      0:       ow = 0;
      1:       ow = 65535;
      2:       ow = 1;
      default: ow = $urandom_range(2, 24);
    endcase
    if (last) ow = 3;
    write_reg(CFG_OUTPUT_WIDTH, 24'(ow));

    // height stays beyond every row end a phase can reach until the closing phase
    if ($urandom_range(0, 4) == 0) oh = 65535;
    else oh = 32'(out_y) + PHASE_ITEMS + 2 + $urandom_range(0, 3000);
    if (oh > 65535) oh = 65535;
    if (last) oh = 0;
    write_reg(CFG_OUTPUT_HEIGHT, 24'(oh));
    cfg_valid <= 1'b0;

    in_gaps  = ($urandom_range(0, 2) != 0);
    out_gaps = ($urandom_range(0, 2) != 0);
    n_phases++;
  endtask

  // ----------------------------------------------------------------------
  // stimulus
  // ----------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    row;
    in_item_t    it;
    out_item_t   want;
    out_item_t   pred;
    bit          prev_cfg;
    int unsigned done_items;
    int unsigned guard;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_item    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_INPUT_WIDTH;
    cfg_data   <= '0;
    in_gaps    = 1'b1;
    out_gaps   = 1'b1;
    hold_asked = 0;

    // model state after reset
    reg_in_w    = 13'd1;
    reg_out_w   = 16'd1;
    reg_out_h   = 16'd1;
    reg_step    = 24'd65536;
    wr_col      = '0;
    rows_loaded = '0;
    out_x       = '0;
    out_y       = '0;
    image_done  = 1'b0;
    foreach (line_written[i]) line_written[i] = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    prev_cfg = 1'b0;
    for (int k = 0; k < $size(DIR_ROWS); k++) begin
      row = DIR_ROWS[k];
      if (row.kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        write_reg(row.reg_idx, row.value);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        prev_cfg = 1'b0;
        it      = '0;
        it.mode = row.mode;
        {it.in_red, it.in_green, it.in_blue} = row.value;
        pred = scale_step(it);
        case (row.kind)
          ROW_REFUSED: want = '0;
          ROW_STORED: begin
            want          = '0;
            want.accepted = 1'b1;
          end
          default: want = pred;
        endcase
        send_txn(it, want);
      end
    end

    // random phases, the image keeps running across them
    for (int ph = 0; ph < PHASES; ph++) begin
      configure_phase(1'b0);
      if (ph == HOLD_PHASE) in_gaps = 1'b0;  // keep offering while the output is held
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        if (ph == HOLD_PHASE && done_items == 5) hold_asked++;
        if (ph == PAUSE_PHASE && done_items == 20) settle();
        it   = next_item($urandom_range(0, 99) < 85);
        want = scale_step(it);
        send_txn(it, want);
        if (want.accepted) done_items++;
      end
    end

    // closing phase: height acts as one, so the image ends at the next row end
    configure_phase(1'b1);
    guard = 0;
    while (!image_done && guard < 4000) begin
      it = next_item(1'b1);
      send_txn(it, scale_step(it));
      guard++;
    end
    // everything after the image is refused
    repeat (6) begin
      it = next_item(1'b0);
      send_txn(it, scale_step(it));
    end

    settle();
    repeat (8) @(posedge clk);

    $display("covered %0d transactions: %0d pixels stored, %0d pixels produced, %0d refused",
             n_txn, n_stored, n_pixels, n_refused);
    $display("%0d row ends and %0d image end over %0d configuration phases, %0d mismatches",
             n_row_end, n_image_end, n_phases + 1, n_errors);
    if (n_errors == 0)
      $display("PASS nearest_neighbor_scaler_unit");
    else
      $display("FAIL nearest_neighbor_scaler_unit");
    $finish;
  end

  // ----------------------------------------------------------------------
  // result side: random stalls, one long hold, in-order checking
  // ----------------------------------------------------------------------
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned hold_left;
    out_item_t   want;
    out_stall  <= 1'b0;
    wait_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    n_errors   = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (px_expected.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("error: unexpected result acc=%0d rgb=%h row_end=%0d img_end=%0d",
                     out_item.accepted, {out_item.out_red, out_item.out_green,
                     out_item.out_blue}, out_item.row_end, out_item.image_end);
        end else begin
          want = px_expected.pop_front();
          if (out_item !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("error: expected acc=%0d rgb=%h row_end=%0d img_end=%0d",
                       want.accepted, {want.out_red, want.out_green, want.out_blue},
                       want.row_end, want.image_end);
              $display("       got      acc=%0d rgb=%h row_end=%0d img_end=%0d",
                       out_item.accepted,
                       {out_item.out_red, out_item.out_green, out_item.out_blue},
                       out_item.row_end, out_item.image_end);
            end
          end
        end
        wait_left = out_gaps ? $urandom_range(0, 11) : 0;
      end
      // long hold asked by the sender, counted here
      if (hold_asked != holds_done) begin
        holds_done = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left != 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    #3_000_000;
    $display("FAIL nearest_neighbor_scaler_unit");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/nns_pkg.sv
rtl/core/nns_ram.sv
rtl/core/nearest_neighbor_scaler_unit.sv
tb/sv/nearest_neighbor_scaler_unit_tb.sv
